FILE: rtl/ilc_pkg.sv
// ilc_pkg: constants, codes, result type and helpers for the ini line classifier
// no dependencies; imported by ilc_result_if, ilc_tracker, ini_line_classifier and ilc_checker
package ilc_pkg;

    // line length and counter ranges
    localparam int LINE_MAX = 4096;
    localparam int POS_W    = $clog2(LINE_MAX);
    localparam int CNT_W    = 16;

    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(LINE_MAX - 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // characters of interest
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // kind of the first non-blank byte of the current line
    localparam logic [1:0] FK_NONE    = 2'd0;
    localparam logic [1:0] FK_COMMENT = 2'd1;
    localparam logic [1:0] FK_SECTION = 2'd2;
    localparam logic [1:0] FK_KEY     = 2'd3;

    // reported line kinds
    localparam logic [2:0] LK_BLANK       = 3'd0;
    localparam logic [2:0] LK_SECTION     = 3'd1;
    localparam logic [2:0] LK_KEY         = 3'd2;
    localparam logic [2:0] LK_BAD_SECTION = 3'd3;
    localparam logic [2:0] LK_NO_EQUALS   = 3'd4;
    localparam logic [2:0] LK_TOO_LONG    = 3'd5;

    // one result request
    typedef struct packed {
        logic [7:0]       out_byte;
        logic             line_done;
        logic [2:0]       line_kind;
        logic [POS_W-1:0] name_start;
        logic [POS_W-1:0] name_end;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_end;
        logic [CNT_W-1:0] line_index;
        logic [CNT_W-1:0] section_number;
        logic             halted;
    } result_t;

    // blanks are tab to carriage return and space
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    // error kinds halt the block
    function automatic logic is_error(input logic [2:0] k);
        return (k == LK_BAD_SECTION) || (k == LK_NO_EQUALS) || (k == LK_TOO_LONG);
    endfunction

endpackage

FILE: rtl/ilc_text_if.sv
// ilc_text_if: input channel carrying one text byte per request
// depends on nothing
interface ilc_text_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, last_byte, output ready);

endinterface

FILE: rtl/ilc_result_if.sv
// ilc_result_if: output channel carrying the echoed byte and the line summary
// depends on ilc_pkg for widths
interface ilc_result_if
    import ilc_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             line_done;
    logic [2:0]       line_kind;
    logic [POS_W-1:0] name_start;
    logic [POS_W-1:0] name_end;
    logic [POS_W-1:0] value_start;
    logic [POS_W-1:0] value_end;
    logic [CNT_W-1:0] line_index;
    logic [CNT_W-1:0] section_number;
    logic             halted;

    modport source (output valid, out_byte, line_done, line_kind, name_start, name_end,
                    value_start, value_end, line_index, section_number, halted,
                    input ready);
    modport sink   (input valid, out_byte, line_done, line_kind, name_start, name_end,
                    value_start, value_end, line_index, section_number, halted,
                    output ready);

endinterface

FILE: rtl/ilc_tracker.sv
// ilc_tracker: per-line parse state, counters and the result for the byte on offer
// depends on ilc_pkg; state advances only on an accepted request
module ilc_tracker
    import ilc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output result_t    res
);

    logic [POS_W-1:0] position_reg,   position_next;
    logic [1:0]       first_kind_reg, first_kind_next;
    logic             marker_seen_reg, marker_seen_next;
    logic [POS_W-1:0] marker_pos_reg, marker_pos_next;
    logic [POS_W-1:0] field_first_reg, field_first_next;
    logic [POS_W-1:0] field_last_reg,  field_last_next;
    logic [POS_W-1:0] tail_first_reg,  tail_first_next;
    logic [POS_W-1:0] tail_last_reg,   tail_last_next;
    logic [POS_W-1:0] nonspace_reg,    nonspace_next;
    logic [CNT_W-1:0] line_count_reg,  line_count_next;
    logic [CNT_W-1:0] section_count_reg, section_count_next;
    logic             stopped_reg,  stopped_next;
    logic             overlong_reg, overlong_next;

    logic             nl;
    logic             sp;
    logic [POS_W-1:0] pos_inc;
    logic [2:0]       kind;
    logic             is_upper;

    // next state and result for the byte on offer
    always_comb
    begin
        position_next      = position_reg;
        first_kind_next    = first_kind_reg;
        marker_seen_next   = marker_seen_reg;
        marker_pos_next    = marker_pos_reg;
        field_first_next   = field_first_reg;
        field_last_next    = field_last_reg;
        tail_first_next    = tail_first_reg;
        tail_last_next     = tail_last_reg;
        nonspace_next      = nonspace_reg;
        line_count_next    = line_count_reg;
        section_count_next = section_count_reg;
        stopped_next       = stopped_reg;
        overlong_next      = overlong_reg;
        res                = '0;
        kind               = LK_BLANK;

        nl       = (in_byte == CH_NEWLINE);
        sp       = is_blank(in_byte);
        pos_inc  = position_reg + 1'b1;
        is_upper = (in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z);

        if (stopped_reg)
        begin
            res.halted = 1'b1;
        end
        else
        begin
            // take a content byte into the line
            if (!nl && !overlong_reg)
            begin
                if (position_reg >= POS_LAST)
                begin
                    overlong_next = 1'b1;
                end
                else
                begin
                    position_next = pos_inc;
                    if (!sp)
                        nonspace_next = pos_inc;
                    unique case (first_kind_reg)
                        FK_NONE:
                        begin
                            if (!sp)
                            begin
                                if ((in_byte == CH_HASH) || (in_byte == CH_SEMI))
                                    first_kind_next = FK_COMMENT;
                                else if (in_byte == CH_LBRACK)
                                    first_kind_next = FK_SECTION;
                                else
                                begin
                                    first_kind_next = FK_KEY;
                                    if (in_byte == CH_EQUALS)
                                    begin
                                        marker_seen_next = 1'b1;
                                        marker_pos_next  = position_reg;
                                    end
                                    else
                                    begin
                                        field_first_next = position_reg;
                                        field_last_next  = pos_inc;
                                    end
                                end
                            end
                        end
                        FK_SECTION:
                        begin
                            if (!marker_seen_reg)
                            begin
                                if (in_byte == CH_RBRACK)
                                begin
                                    marker_seen_next = 1'b1;
                                    marker_pos_next  = position_reg;
                                end
                                else if (!sp)
                                begin
                                    if (field_last_reg == '0)
                                        field_first_next = position_reg;
                                    field_last_next = pos_inc;
                                end
                            end
                        end
                        FK_KEY:
                        begin
                            if (!marker_seen_reg)
                            begin
                                if (in_byte == CH_EQUALS)
                                begin
                                    marker_seen_next = 1'b1;
                                    marker_pos_next  = position_reg;
                                end
                                else if (!sp)
                                begin
                                    if (field_last_reg == '0)
                                        field_first_next = position_reg;
                                    field_last_next = pos_inc;
                                end
                            end
                            else if (!sp)
                            begin
                                if (tail_last_reg == '0)
                                    tail_first_next = position_reg;
                                tail_last_next = pos_inc;
                            end
                        end
                        default:
                        begin
                            // comment lines are not parsed further
                        end
                    endcase
                end
            end

            // echo, lowercased once the line opened with a bracket
            res.out_byte = ((first_kind_next == FK_SECTION) && is_upper) ?
                           (in_byte | CASE_BIT) : in_byte;

            // close the line
            if (nl || last_byte)
            begin
                if (line_count_reg != COUNT_MAX)
                    line_count_next = line_count_reg + 1'b1;

                priority if (overlong_next)
                    kind = LK_TOO_LONG;
                else if ((first_kind_next == FK_NONE) || (first_kind_next == FK_COMMENT))
                    kind = LK_BLANK;
                else if (first_kind_next == FK_SECTION)
                begin
                    if (marker_seen_next && (nonspace_next == marker_pos_next + 1'b1))
                    begin
                        kind = LK_SECTION;
                        if (section_count_reg != COUNT_MAX)
                            section_count_next = section_count_reg + 1'b1;
                        if (field_last_next != '0)
                        begin
                            res.name_start = field_first_next;
                            res.name_end   = field_last_next;
                        end
                    end
                    else
                        kind = LK_BAD_SECTION;
                end
                else
                begin
                    if (marker_seen_next)
                    begin
                        kind = LK_KEY;
                        if (field_last_next != '0)
                        begin
                            res.name_start = field_first_next;
                            res.name_end   = field_last_next;
                        end
                        if (tail_last_next != '0)
                        begin
                            res.value_start = tail_first_next;
                            res.value_end   = tail_last_next;
                        end
                    end
                    else
                        kind = LK_NO_EQUALS;
                end

                if (kind != LK_BLANK)
                    res.section_number = section_count_next;
                if (is_error(kind))
                    stopped_next = 1'b1;
                res.line_done  = 1'b1;
                res.line_kind  = kind;
                res.line_index = line_count_next;

                // fresh line
                position_next    = '0;
                first_kind_next  = FK_NONE;
                marker_seen_next = 1'b0;
                marker_pos_next  = '0;
                field_first_next = '0;
                field_last_next  = '0;
                tail_first_next  = '0;
                tail_last_next   = '0;
                nonspace_next    = '0;
                overlong_next    = 1'b0;
            end
            res.halted = stopped_next;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= '0;
            first_kind_reg    <= FK_NONE;
            marker_seen_reg   <= 1'b0;
            marker_pos_reg    <= '0;
            field_first_reg   <= '0;
            field_last_reg    <= '0;
            tail_first_reg    <= '0;
            tail_last_reg     <= '0;
            nonspace_reg      <= '0;
            line_count_reg    <= '0;
            section_count_reg <= '0;
            stopped_reg       <= 1'b0;
            overlong_reg      <= 1'b0;
        end
        else if (take)
        begin
            position_reg      <= position_next;
            first_kind_reg    <= first_kind_next;
            marker_seen_reg   <= marker_seen_next;
            marker_pos_reg    <= marker_pos_next;
            field_first_reg   <= field_first_next;
            field_last_reg    <= field_last_next;
            tail_first_reg    <= tail_first_next;
            tail_last_reg     <= tail_last_next;
            nonspace_reg      <= nonspace_next;
            line_count_reg    <= line_count_next;
            section_count_reg <= section_count_next;
            stopped_reg       <= stopped_next;
            overlong_reg      <= overlong_next;
        end
    end

endmodule

FILE: rtl/ini_line_classifier.sv
// ini_line_classifier: streaming ini line classifier, top level
// depends on ilc_pkg, ilc_text_if, ilc_result_if and ilc_tracker
//
// Usage:
//   text   - one text byte per request, last_byte marks the final byte of the stream
//   result - one request per accepted byte: the echoed byte (lowercased on a bracket
//            line) and, when line_done is set, the kind, trimmed name and value
//            offsets, line number and section count of the line just closed
// Latency: a result is shown on the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; the parse state and counters update in the
//   same cycle as the byte is taken, and a single output register holds the result.
// Stall: while the result register is full and not taken, text.ready is low and
//   the held result stays unchanged; ready returns in the cycle the result is taken.
// Reset: clears the line state, line and section counters and the halt flag;
//   the result register is empty after reset.
// An error line (bad section, missing equals, too long) sets halted; from then on
//   every byte is accepted and answered with a result that carries only halted,
//   until the next reset.
module ini_line_classifier
    import ilc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ilc_text_if.sink           text,
    ilc_result_if.source       result
);

    logic    take;
    result_t res;
    result_t result_reg;
    logic    valid_reg;

    // accept whenever the output register is free or being emptied
    assign text.ready = !valid_reg || result.ready;
    assign take       = text.valid && text.ready;

    ilc_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (text.in_byte),
        .last_byte (text.last_byte),
        .res       (res)
    );

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= res;
    end

    assign result.valid          = valid_reg;
    assign result.out_byte       = result_reg.out_byte;
    assign result.line_done      = result_reg.line_done;
    assign result.line_kind      = result_reg.line_kind;
    assign result.name_start     = result_reg.name_start;
    assign result.name_end       = result_reg.name_end;
    assign result.value_start    = result_reg.value_start;
    assign result.value_end      = result_reg.value_end;
    assign result.line_index     = result_reg.line_index;
    assign result.section_number = result_reg.section_number;
    assign result.halted         = result_reg.halted;

endmodule

FILE: rtl/ilc_checker.sv
// ilc_checker: port-level assertions for the ini line classifier, bound to the top level
// depends on ilc_pkg
module ilc_checker
    import ilc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [7:0]       out_byte,
    input logic             line_done,
    input logic [2:0]       line_kind,
    input logic [POS_W-1:0] name_start,
    input logic [POS_W-1:0] name_end,
    input logic [POS_W-1:0] value_start,
    input logic [POS_W-1:0] value_end,
    input logic [CNT_W-1:0] line_index,
    input logic             halted
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(line_index))
    else $error("stalled result changed");

    // summary fields are zero on bytes that close no line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_done |-> (line_kind == LK_BLANK) && (line_index == '0)
            && (name_start == '0) && (name_end == '0)
            && (value_start == '0) && (value_end == '0))
    else $error("summary fields set without a closed line");

    // a closed line while halted can only be the error line itself
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted && line_done |->
            (line_kind == LK_BAD_SECTION) || (line_kind == LK_NO_EQUALS)
            || (line_kind == LK_TOO_LONG))
    else $error("line closed after halt");

    // name and value offsets are ordered and counted lines start from one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> (name_start <= name_end) && (value_start <= value_end)
            && (line_index != '0))
    else $error("bad offsets or line number");

endmodule

bind ini_line_classifier ilc_checker u_ilc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_byte    (result.out_byte),
    .line_done   (result.line_done),
    .line_kind   (result.line_kind),
    .name_start  (result.name_start),
    .name_end    (result.name_end),
    .value_start (result.value_start),
    .value_end   (result.value_end),
    .line_index  (result.line_index),
    .halted      (result.halted)
);
